>>> rtl/lfys_pkg.sv
`timescale 1ns / 1ps
package lfys_pkg;

  localparam int DEFAULT_DECK_DEPTH    = 64;
  localparam int DEFAULT_ELEMENT_WIDTH = 8;

  localparam int ACTION_W    = 2;
  localparam int INDEX_W     = 6;
  localparam int VALUE_W     = 8;
  localparam int ELEMENT_W   = 8;
  localparam int POSITION_W  = 6;
  localparam int DECK_SIZE_W = 7;

  localparam logic [DECK_SIZE_W-1:0] DECK_SIZE_RESET = 7'd64;

  localparam logic [31:0] LCG_MUL   = 32'd214013;
  localparam logic [31:0] LCG_ADD   = 32'd2531011;
  localparam logic [31:0] LCG_SEED  = 32'd1;
  localparam int          DRAW_LSB  = 16;
  localparam int          DRAW_BITS = 15;
  localparam int          DRAW_CNT_W = $clog2(DRAW_BITS);

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE   = 2'd0,
    ACT_FILL    = 2'd1,
    ACT_DISCARD = 2'd2,
    ACT_SHUFFLE = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_STEP,
    S_DIV_GO,
    S_DIV_WAIT,
    S_RD_I,
    S_RD_J,
    S_WR_I,
    S_WR_J,
    S_EM_RD,
    S_EM_LD,
    S_EM_OUT
  } state_e;

endpackage

>>> rtl/lfys_lcg.sv
`timescale 1ns / 1ps
module lfys_lcg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  output logic [lfys_pkg::DRAW_BITS-1:0] draw_o
);
  import lfys_pkg::*;

  logic [31:0] seed_q, seed_d;

  assign seed_d = step_i ? (seed_q * LCG_MUL + LCG_ADD) : seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= LCG_SEED;
    end else begin
      seed_q <= seed_d;
    end
  end

  assign draw_o = seed_q[DRAW_LSB +: DRAW_BITS];

endmodule

>>> rtl/lfys_mod_unit.sv
`timescale 1ns / 1ps
module lfys_mod_unit #(
  parameter int VW = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lfys_pkg::DRAW_BITS-1:0] dividend_i,
  input  logic [VW-1:0]                 divisor_i,
  output logic                          done_o,
  output logic [VW-1:0]                 rem_o
);
  import lfys_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DRAW_CNT_W-1:0] cnt_q, cnt_d;
  logic [DRAW_BITS-1:0]  dq_q, dq_d;
  logic [VW-1:0]         div_q, div_d;
  logic [VW-1:0]         rem_q, rem_d;
  logic [VW:0]           trial;
  logic [VW:0]           diff;
  logic                  last_step;

  assign trial     = {rem_q, dq_q[DRAW_BITS-1]};
  assign diff      = trial - {1'b0, div_q};
  assign last_step = (cnt_q == DRAW_CNT_W'(DRAW_BITS - 1));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dq_d   = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dq_d  = dq_q << 1;
      cnt_d = cnt_q + DRAW_CNT_W'(1);
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[VW-1:0];
      end else begin
        rem_d = trial[VW-1:0];
      end
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> rtl/lfys_deck_ram.sv
`timescale 1ns / 1ps
module lfys_deck_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/lcg_fisher_yates_shuffler_core.sv
`timescale 1ns / 1ps
// Shuffle engine with a deck memory and a 32-bit linear congruential generator.
// The request channel (in_valid_i/in_ready_o) carries action_i, index_i and value_i.
// A request is taken only while the engine is idle; write and discard requests
// are handled without leaving the idle state, and an identity fill sweeps all DECK_DEPTH entries.
// A shuffle of n entries performs n-1 swaps, each made of one generator step, a
// bit-serial modulo unit run, and reads and writes of entries i and j on the deck
// memory. It then emits n results on out_valid_o/out_ready_i, one at a time: the
// next entry is read from the deck only after the current result has been taken.
// A result is held in the output register until it is taken; a stalled receiver
// simply holds the engine, and no new request is taken until the last result is out.
// deck_size_i is written whenever deck_size_we_i is high and should change only
// while the engine is idle. Reset seeds the generator with 1, sets the deck size
// to 64 and leaves the deck contents undefined until written.
module lcg_fisher_yates_shuffler_core #(
  parameter int DECK_DEPTH    = lfys_pkg::DEFAULT_DECK_DEPTH,
  parameter int ELEMENT_WIDTH = lfys_pkg::DEFAULT_ELEMENT_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              deck_size_we_i,
  input  logic [lfys_pkg::DECK_SIZE_W-1:0]  deck_size_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [lfys_pkg::ACTION_W-1:0]     action_i,
  input  logic [lfys_pkg::INDEX_W-1:0]      index_i,
  input  logic [lfys_pkg::VALUE_W-1:0]      value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lfys_pkg::ELEMENT_W-1:0]    element_o,
  output logic [lfys_pkg::POSITION_W-1:0]   position_o,
  output logic                              last_o
);
  import lfys_pkg::*;

  localparam int AW = $clog2(DECK_DEPTH);
  localparam int CW = $clog2(DECK_DEPTH + 1);

  state_e state_q, state_d;

  logic [DECK_SIZE_W-1:0] deck_size_q;
  logic [CW-1:0]          n_q, n_calc;
  logic [AW-1:0]          i_q, j_q, fill_q;
  logic [ELEMENT_WIDTH-1:0] tmp_q;
  logic                   out_valid_q;
  logic [ELEMENT_W-1:0]   element_q;
  logic [POSITION_W-1:0]  position_q;
  logic                   last_q;

  logic                   in_fire, out_fire;
  logic                   index_ok;
  logic [31:0]            size_ext;
  logic [CW-1:0]          i_ext;
  logic                   more_swaps;
  logic                   last_pos;

  logic                   lcg_step;
  logic [DRAW_BITS-1:0]   draw;
  logic                   div_start, div_done;
  logic [CW-1:0]          divisor, rem;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [ELEMENT_WIDTH-1:0] mem_wdata, mem_rdata;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_q && out_ready_i;
  assign index_ok = (32'(index_i) < DECK_DEPTH);
  assign size_ext = 32'(deck_size_q);
  assign i_ext    = CW'(i_q);
  assign divisor  = n_q - i_ext;
  assign more_swaps = ((i_ext + CW'(2)) < n_q);
  assign last_pos   = ((i_ext + CW'(1)) == n_q);

  always_comb begin
    if (deck_size_q == '0) begin
      n_calc = CW'(1);
    end else if (size_ext > DECK_DEPTH) begin
      n_calc = CW'(DECK_DEPTH);
    end else begin
      n_calc = CW'(deck_size_q);
    end
  end

  lfys_lcg u_lcg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (lcg_step),
    .draw_o (draw)
  );

  lfys_mod_unit #(
    .VW (CW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (draw),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  lfys_deck_ram #(
    .DEPTH (DECK_DEPTH),
    .WIDTH (ELEMENT_WIDTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (action_i == ACT_FILL) begin
            state_d = S_FILL;
          end else if (action_i == ACT_SHUFFLE) begin
            state_d = (n_calc == CW'(1)) ? S_EM_RD : S_STEP;
          end
        end
      end
      S_FILL: begin
        if (fill_q == AW'(DECK_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_STEP:     state_d = S_DIV_GO;
      S_DIV_GO:   state_d = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) begin
          state_d = S_RD_I;
        end
      end
      S_RD_I:     state_d = S_RD_J;
      S_RD_J:     state_d = S_WR_I;
      S_WR_I:     state_d = S_WR_J;
      S_WR_J:     state_d = more_swaps ? S_STEP : S_EM_RD;
      S_EM_RD:    state_d = S_EM_LD;
      S_EM_LD:    state_d = S_EM_OUT;
      S_EM_OUT: begin
        if (out_fire) begin
          state_d = last_q ? S_IDLE : S_EM_RD;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    lcg_step   = 1'b0;
    div_start  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = i_q;
    mem_wdata  = mem_rdata;
    mem_raddr  = i_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        mem_waddr  = AW'(index_i);
        mem_wdata  = ELEMENT_WIDTH'(value_i);
        if (in_fire && action_i == ACT_WRITE && index_ok) begin
          mem_we = 1'b1;
        end
        if (in_fire && action_i == ACT_DISCARD) begin
          lcg_step = 1'b1;
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_q;
        mem_wdata = ELEMENT_WIDTH'(fill_q);
      end
      S_STEP:   lcg_step  = 1'b1;
      S_DIV_GO: div_start = 1'b1;
      S_RD_J:   mem_raddr = j_q;
      S_WR_I: begin
        mem_we    = 1'b1;
        mem_waddr = i_q;
        mem_wdata = mem_rdata;
      end
      S_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = tmp_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      deck_size_q <= DECK_SIZE_RESET;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      fill_q      <= '0;
      n_q         <= CW'(1);
    end else begin
      state_q <= state_d;
      if (deck_size_we_i) begin
        deck_size_q <= deck_size_i;
      end
      case (state_q)
        S_IDLE: begin
          fill_q <= '0;
          i_q    <= '0;
          if (in_fire && action_i == ACT_SHUFFLE) begin
            n_q <= n_calc;
          end
        end
        S_FILL:   fill_q <= fill_q + AW'(1);
        S_WR_J:   i_q    <= more_swaps ? (i_q + AW'(1)) : '0;
        S_EM_LD:  out_valid_q <= 1'b1;
        S_EM_OUT: begin
          if (out_fire) begin
            out_valid_q <= 1'b0;
            i_q         <= i_q + AW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DIV_WAIT && div_done) begin
      j_q <= i_q + AW'(rem);
    end
    if (state_q == S_RD_J) begin
      tmp_q <= mem_rdata;
    end
    if (state_q == S_EM_LD) begin
      element_q  <= ELEMENT_W'(mem_rdata);
      position_q <= POSITION_W'(i_q);
      last_q     <= last_pos;
    end
  end

  assign out_valid_o = out_valid_q;
  assign element_o   = element_q;
  assign position_o  = position_q;
  assign last_o      = last_q;

endmodule

>>> rtl/lfys_checker.sv
`timescale 1ns / 1ps
module lfys_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [lfys_pkg::ACTION_W-1:0]     action_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [lfys_pkg::ELEMENT_W-1:0]    element_o,
  input logic [lfys_pkg::POSITION_W-1:0]   position_o,
  input logic                              last_o
);
  import lfys_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(element_o) && $stable(position_o) && $stable(last_o))
    else $error("result changed while stalled");

  a_no_request_while_emitting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("request taken while a result is pending");

  a_busy_after_inner_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> !in_ready_o)
    else $error("engine idle before the last result");

  a_shuffle_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i == ACT_SHUFFLE |=> !in_ready_o && !out_valid_o)
    else $error("shuffle did not start");

  a_quiet_actions: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i != ACT_SHUFFLE |=> !out_valid_o)
    else $error("result from a request that yields none");

endmodule

bind lcg_fisher_yates_shuffler_core lfys_checker u_lfys_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .action_i    (action_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .element_o   (element_o),
  .position_o  (position_o),
  .last_o      (last_o)
);
